// File: rtl/nsr_pkg.sv
package nsr_pkg;

    // Data format of the radicand, the guess and every estimate.
    localparam int DATA_WIDTH     = 32;
    localparam int FRACTION_BITS  = 16;
    localparam int MAX_ITERATIONS = 32;

    localparam int TOL_W  = 16;
    localparam int STEP_W = 6;
    localparam int STAT_W = 2;

    // Width of x*x and of the radicand aligned to it.
    localparam int SQ_W = 2 * DATA_WIDTH;
    // The divider works on half the magnitude, so one bit fewer.
    localparam int DIV_NUM_W = SQ_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [STEP_W-1:0]     step_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_CONVERGED  = 2'd0,
        STATUS_ZERO_GUESS = 2'd1,
        STATUS_LIMIT      = 2'd2
    } nsr_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MULT,
        ST_DIFF,
        ST_DIVIDE,
        ST_UPDATE,
        ST_OUTPUT
    } nsr_state_t;

endpackage

// File: rtl/nsr_if.sv
interface nsr_in_if;
    import nsr_pkg::*;

    logic  valid;
    logic  ready;
    data_t radicand;
    data_t initial_guess;

    modport source (output valid, output radicand, output initial_guess, input ready);
    modport sink   (input valid, input radicand, input initial_guess, output ready);
endinterface

interface nsr_out_if;
    import nsr_pkg::*;

    logic              valid;
    logic              ready;
    data_t             root;
    logic [STAT_W-1:0] status;
    step_t             iterations_used;

    modport source (output valid, output root, output status, output iterations_used,
                    input ready);
    modport sink   (input valid, input root, input status, input iterations_used,
                    output ready);
endinterface

// File: rtl/nsr_divider.sv
module nsr_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [nsr_pkg::DIV_NUM_W-1:0]    numerator,
    input  nsr_pkg::data_t                   divisor,
    output logic                             done,
    output logic [nsr_pkg::DIV_NUM_W-1:0]    quotient
);
    import nsr_pkg::*;

    // Restoring division, one quotient bit per cycle, most significant first.
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    data_t                rem_reg;
    data_t                div_reg;

    logic [DATA_WIDTH:0]  rem_shift;
    logic                 take;
    data_t                rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, num_reg[DIV_NUM_W-1]};
        take      = rem_shift >= {1'b0, div_reg};
        if (take)
        begin
            rem_next = DATA_WIDTH'(rem_shift - {1'b0, div_reg});
        end
        else
        begin
            rem_next = rem_shift[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numerator;
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/newton_square_root_unit.sv
// From acceptance, a zero guess goes straight to the output stage. Any other guess is
// checked for convergence first, and each Newton step then passes through square,
// difference, divide and update before the next check; the divider sets the step time.
// A new item is taken only once the sequencer has placed the last result and is idle again.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle, drops the result
// valid and sets the tolerance register to 1.
module newton_square_root_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tolerance_we,
    input  logic [nsr_pkg::TOL_W-1:0]   tolerance_wdata,
    nsr_in_if.sink                      req,
    nsr_out_if.source                   rsp
);
    import nsr_pkg::*;

    localparam data_t MAXV = '1;

    // Sequencer state and the working registers of one item.
    nsr_state_t        state_reg, state_next;
    logic [TOL_W-1:0]  tol_reg;
    data_t             num_reg, num_next;
    data_t             cur_reg, cur_next;
    data_t             prev_reg, prev_next;
    step_t             steps_reg, steps_next;
    nsr_status_t       stat_reg, stat_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic              below_reg, below_next;

    // Result held for the downstream side, so the sequencer can be released.
    logic              out_valid_reg, out_valid_next;
    data_t             out_root_reg, out_root_next;
    nsr_status_t       out_stat_reg, out_stat_next;
    step_t             out_steps_reg, out_steps_next;

    // Divider for the Newton step.
    logic                 div_start;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_NUM_W-1:0] div_quo;

    logic [SQ_W-1:0]      aligned_num;
    logic                 below_now;
    logic [SQ_W-1:0]      magnitude;
    data_t                est_diff;
    logic [DATA_WIDTH:0]  up_sum;
    logic                 up_saturate;

    nsr_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (div_num),
        .divisor   (cur_reg),
        .done      (div_done),
        .quotient  (div_quo)
    );

    // The radicand is brought to the format of x*x, and the magnitude of the error is
    // halved on its way into the divider: floor(floor(m/2)/x) equals floor(m/(2x)).
    always_comb
    begin
        aligned_num = SQ_W'(num_reg) << FRACTION_BITS;
        below_now   = sq_reg < aligned_num;
        if (below_now)
        begin
            magnitude = aligned_num - sq_reg;
        end
        else
        begin
            magnitude = sq_reg - aligned_num;
        end
        div_num   = magnitude[SQ_W-1:1];
        div_start = (state_reg == ST_DIFF);

        if (cur_reg >= prev_reg)
        begin
            est_diff = cur_reg - prev_reg;
        end
        else
        begin
            est_diff = prev_reg - cur_reg;
        end

        // A step upward saturates at the largest estimate.
        up_sum      = {1'b0, cur_reg} + {1'b0, div_quo[DATA_WIDTH-1:0]};
        up_saturate = (div_quo[DIV_NUM_W-1:DATA_WIDTH] != '0) || up_sum[DATA_WIDTH];
    end

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        steps_next     = steps_reg;
        stat_next      = stat_reg;
        sq_next        = sq_reg;
        below_next     = below_reg;
        out_valid_next = out_valid_reg;
        out_root_next  = out_root_reg;
        out_stat_next  = out_stat_reg;
        out_steps_next = out_steps_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    num_next   = req.radicand;
                    cur_next   = req.initial_guess;
                    prev_next  = '0;
                    steps_next = '0;
                    if (req.initial_guess == '0)
                    begin
                        stat_next  = STATUS_ZERO_GUESS;
                        state_next = ST_OUTPUT;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                // Convergence is tested before the step limit.
                if (est_diff <= DATA_WIDTH'(tol_reg))
                begin
                    stat_next  = STATUS_CONVERGED;
                    state_next = ST_OUTPUT;
                end
                else if (steps_reg >= STEP_W'(MAX_ITERATIONS))
                begin
                    stat_next  = STATUS_LIMIT;
                    state_next = ST_OUTPUT;
                end
                else
                begin
                    prev_next  = cur_reg;
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                sq_next    = cur_reg * cur_reg;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                below_next = below_now;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!below_reg)
                begin
                    cur_next = cur_reg - div_quo[DATA_WIDTH-1:0];
                end
                else if (up_saturate)
                begin
                    cur_next = MAXV;
                end
                else
                begin
                    cur_next = up_sum[DATA_WIDTH-1:0];
                end
                steps_next = steps_reg + 1'b1;
                state_next = ST_CHECK;
            end
            ST_OUTPUT:
            begin
                // A zero guess leaves the estimate at zero, which is the root it reports.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_root_next  = cur_reg;
                    out_stat_next  = stat_reg;
                    out_steps_next = steps_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            tol_reg       <= TOL_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (tolerance_we)
            begin
                tol_reg <= tolerance_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        steps_reg     <= steps_next;
        stat_reg      <= stat_next;
        sq_reg        <= sq_next;
        below_reg     <= below_next;
        out_root_reg  <= out_root_next;
        out_stat_reg  <= out_stat_next;
        out_steps_reg <= out_steps_next;
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.root            = out_root_reg;
    assign rsp.status          = out_stat_reg;
    assign rsp.iterations_used = out_steps_reg;

endmodule

// File: test/newton_square_root_unit_tb.sv
`timescale 1ns / 1ps

module newton_square_root_unit_tb;
    import nsr_pkg::*;

    // The clock period is 12 ns, and reset is held low at the start.
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 7;
    // The limit lies well above a full run of MAX_ITERATIONS steps and above the long
    // output hold-off; no correct run goes this long without any handshake.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 4000;
    // Extra wait after the last result before the tolerance register is written.
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 50;
    localparam int MAX_WAIT       = 18;

    // Hand-picked items. They cover the zero guess, a guess within tolerance of zero,
    // a step up that saturates at the top of the range, exact roots, all-ones and
    // alternating bit patterns, and a halving run of exactly MAX_ITERATIONS steps
    // that converges on its final step.
    localparam int EDGE_COUNT = 17;
    localparam data_t EDGE_RADICANDS [EDGE_COUNT] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0001_0000, 32'h0004_0000, 32'hFFFF_FFFF, 32'h0000_0000,
        32'h0000_0000, 32'h0002_0000, 32'hAAAA_AAAA, 32'h5555_5555,
        32'h0000_0001, 32'h0000_0001, 32'hFFFF_0000, 32'h0000_0001,
        32'h1234_5678
    };
    localparam data_t EDGE_GUESSES [EDGE_COUNT] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
        32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h8000_0000, 32'h0001_0000, 32'h5555_5555, 32'hAAAA_AAAA,
        32'h0000_0001, 32'h0000_0003, 32'h0100_0000, 32'hFFFF_FFFF,
        32'h0000_2000
    };

    // One expected result, together with the item that caused it so that a mismatch
    // report can show where it came from.
    typedef struct packed {
        data_t       radicand;
        data_t       guess;
        data_t       root;
        nsr_status_t status;
        step_t       iterations;
    } root_result_t;

    // The scoreboard keeps its own copy of the tolerance register, works out the
    // result of every accepted item, and checks results against them in order.
    class root_ledger;
        bit [TOL_W-1:0] tolerance;
        root_result_t   awaited_roots[$];
        int             errors;

        function new();
            tolerance = TOL_W'(1);
            errors    = 0;
        endfunction

        function void set_tolerance(bit [TOL_W-1:0] value);
            tolerance = value;
        endfunction

        function int outstanding();
            return awaited_roots.size();
        endfunction

        // Runs the Newton iteration on one accepted item. The previous estimate
        // starts at zero, so the first convergence test compares the guess with zero.
        function void note_radicand(data_t radicand, data_t guess);
            root_result_t   want;
            data_t          estimate;
            data_t          prior;
            data_t          change;
            bit [SQ_W-1:0]  square;
            bit [SQ_W-1:0]  aligned;
            bit [SQ_W-1:0]  magnitude;
            bit [SQ_W-1:0]  step_size;
            bit [SQ_W:0]    raised;
            bit             below;
            bit             done;
            int             steps;

            want.radicand = radicand;
            want.guess    = guess;
            if (guess == '0)
            begin
                want.root       = '0;
                want.status     = STATUS_ZERO_GUESS;
                want.iterations = '0;
            end
            else
            begin
                estimate = guess;
                prior    = '0;
                steps    = 0;
                done     = 1'b0;
                while (!done)
                begin
                    change = (estimate >= prior) ? estimate - prior : prior - estimate;
                    // Convergence is tested before the step limit.
                    if (change <= DATA_WIDTH'(tolerance))
                    begin
                        want.status = STATUS_CONVERGED;
                        done        = 1'b1;
                    end
                    else if (steps >= MAX_ITERATIONS)
                    begin
                        want.status = STATUS_LIMIT;
                        done        = 1'b1;
                    end
                    else
                    begin
                        square    = SQ_W'(estimate) * SQ_W'(estimate);
                        aligned   = SQ_W'(radicand) << FRACTION_BITS;
                        below     = square < aligned;
                        magnitude = below ? aligned - square : square - aligned;
                        step_size = (magnitude >> 1) / SQ_W'(estimate);
                        prior     = estimate;
                        if (!below)
                        begin
                            estimate = estimate - step_size[DATA_WIDTH-1:0];
                        end
                        else
                        begin
                            // A step up past the top of the range saturates.
                            raised = {1'b0, step_size} + (SQ_W + 1)'(estimate);
                            if (raised[SQ_W:DATA_WIDTH] != '0)
                                estimate = '1;
                            else
                                estimate = raised[DATA_WIDTH-1:0];
                        end
                        steps++;
                    end
                end
                want.root       = estimate;
                want.iterations = step_t'(steps);
            end
            awaited_roots.push_back(want);
        endfunction

        function void check_root(data_t root, logic [STAT_W-1:0] status, step_t iterations);
            root_result_t want;

            if (awaited_roots.size() == 0)
            begin
                if (errors < 10)
                    $display("%0t: result with nothing awaited: root %h status %0d iter %0d",
                             $realtime, root, status, iterations);
                errors++;
                return;
            end
            want = awaited_roots.pop_front();
            if (root !== want.root || status !== want.status
                || iterations !== want.iterations)
            begin
                if (errors < 10)
                    $display("%0t: mismatch %h,%h: root %h/%h st %0d/%0d it %0d/%0d (exp/act)",
                             $realtime, want.radicand, want.guess, want.root, root,
                             want.status, status, want.iterations, iterations);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 tolerance_we;
    logic [TOL_W-1:0]     tolerance_wdata;

    nsr_in_if  req_if ();
    nsr_out_if rsp_if ();

    root_ledger ledger;
    int         sender_calm;

    newton_square_root_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .tolerance_we    (tolerance_we),
        .tolerance_wdata (tolerance_wdata),
        .req             (req_if),
        .rsp             (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Each side draws its own wait before every item. Now and then it enters a calm
    // stretch of back-to-back items so that full-rate phases are exercised as well.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Offers one item and returns at the edge where it is accepted. Valid stays high
    // after acceptance; the caller either offers the next item in the same time step
    // or lowers valid, so valid never gets two assignments in one step.
    task automatic offer_item(input data_t radicand, input data_t guess);
        int gap;

        gap = draw_wait(sender_calm);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.radicand      <= radicand;
        req_if.initial_guess <= guess;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        ledger.note_radicand(radicand, guess);
    endtask

    // The tolerance register is written only when the block is idle: every expected
    // result has come back and a few extra cycles have passed.
    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        req_if.valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        tolerance_we    <= 1'b1;
        tolerance_wdata <= value;
        @(posedge clk);
        tolerance_we    <= 1'b0;
        ledger.set_tolerance(value);
    endtask

    // Random items. Most guesses sit near the true root, so the iteration converges in
    // a handful of steps; the rest are zero, tiny, or anywhere in the 32-bit range,
    // which drives the long halving runs and the saturating step up.
    task automatic run_random_items(input int count);
        data_t rad;
        data_t guess;
        data_t base;
        data_t delta;
        real   exact_root;
        int    pick;

        repeat (count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                rad = $urandom;
            else if (pick < 8)
                rad = $urandom >> $urandom_range(0, 31);
            else if (pick == 8)
                rad = '0;
            else
                rad = '1;

            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                guess = '0;
            end
            else if (pick < 15)
            begin
                guess = $urandom_range(1, 2 * ledger.tolerance + 2);
            end
            else if (pick < 35)
            begin
                guess = $urandom;
            end
            else
            begin
                exact_root = $sqrt(real'(rad) * (2.0 ** FRACTION_BITS));
                base       = $rtoi(exact_root);
                delta      = base >> $urandom_range(1, 12);
                guess      = ($urandom_range(0, 1) != 0) ? base + delta : base - delta;
                guess      = guess + $urandom_range(0, 3);
                if (guess == '0)
                    guess = 1;
            end
            offer_item(rad, guess);
        end
    endtask

    // The result side. Ready is lowered for a random number of cycles before each
    // result, and twice it is held low for a long stretch while the sender keeps
    // offering, so the block stalls with a result waiting and its input blocked.
    initial
    begin : result_sink
        int stall;
        int results_taken;
        int calm;

        rsp_if.ready  <= 1'b0;
        results_taken = 0;
        calm          = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_taken == 150 || results_taken == 520)
                stall = LONG_HOLD;
            else
                stall = draw_wait(calm);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_if.valid !== 1'b1);
            ledger.check_root(rsp_if.root, rsp_if.status, rsp_if.iterations_used);
            results_taken++;
        end
    end

    // The watchdog ends the run if no handshake happens on either side for too long.
    initial
    begin : watchdog
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1)
                || (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("newton_square_root_unit regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        ledger      = new();
        sender_calm = 0;

        rst_n                <= 1'b0;
        tolerance_we         <= 1'b0;
        tolerance_wdata      <= '0;
        req_if.valid         <= 1'b0;
        req_if.radicand      <= '0;
        req_if.initial_guess <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The hand-picked items run with the tolerance left at its reset value of 1.
        for (int i = 0; i < EDGE_COUNT; i++)
            offer_item(EDGE_RADICANDS[i], EDGE_GUESSES[i]);

        // With zero tolerance the halving run from the top of the range settles at one
        // and cannot converge, so it ends on the step limit.
        write_tolerance('0);
        offer_item('0, '1);
        run_random_items(50);

        // The largest tolerance, just under one whole unit in Q16.16.
        write_tolerance('1);
        run_random_items(60);

        write_tolerance(TOL_W'($urandom_range(2, 64)));
        run_random_items(250);

        write_tolerance(TOL_W'($urandom_range(65, 4096)));
        run_random_items(250);

        write_tolerance(TOL_W'(1));
        run_random_items(190);

        req_if.valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        // A few more cycles catch any result that would come without an item.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.outstanding() != 0)
            $display("%0d expected results never arrived", ledger.outstanding());
        if (ledger.errors == 0 && ledger.outstanding() == 0)
            $display("newton_square_root_unit regression: pass");
        else
            $display("newton_square_root_unit regression: fail");
        $finish;
    end

endmodule
